// ===== hw/rtl/sdrt_pkg.sv =====
// shared constants, codes and types of the sorted date record table
package sdrt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 21;
	localparam int TAG_W = 8;
	localparam int DAY_W = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W = 12;
	localparam int DAYS_PER_YEAR = 365;
	localparam int DAYS_PER_MONTH = 30;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} ctl_t;

endpackage

// ===== hw/rtl/sdrt_ctrl.sv =====
// controller: command sequencing and output handshake for the record table
module sdrt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output sdrt_pkg::ctl_t ctl
);

	sdrt_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic in_xfer;

	// a new command may come in while idle once the result slot is free or being emptied
	assign in_ready = (state_q == sdrt_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sdrt_pkg::S_IDLE: begin
				if (in_xfer) begin
					state_nxt = sdrt_pkg::S_EXEC;
				end
			end
			sdrt_pkg::S_EXEC: begin
				state_nxt = sdrt_pkg::S_IDLE;
			end
			default: begin
				state_nxt = sdrt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			sdrt_pkg::S_IDLE: begin
				ctl.capture = in_xfer;
			end
			sdrt_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdrt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_exec_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sdrt_pkg::S_EXEC |-> !out_valid_q)
		else $error("result slot occupied during execute");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> out_valid_q)
		else $error("execute did not produce a result");

	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == sdrt_pkg::S_EXEC)
		else $error("accepted command not executed");

endmodule

// ===== hw/rtl/sdrt_datapath.sv =====
// datapath: date key, sorted record cells, fill count and result register
module sdrt_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sdrt_pkg::ctl_t                 ctl,
	input  logic [1:0]                     cmd,
	input  logic [sdrt_pkg::TAG_W-1:0]     record_tag,
	input  logic [sdrt_pkg::DAY_W-1:0]     birth_day,
	input  logic [sdrt_pkg::MONTH_W-1:0]   birth_month,
	input  logic [sdrt_pkg::YEAR_W-1:0]    birth_year,
	input  logic [sdrt_pkg::IDX_W-1:0]     position,
	output logic [1:0]                     status,
	output logic [sdrt_pkg::CNT_W-1:0]     entry_count,
	output logic [sdrt_pkg::TAG_W-1:0]     out_tag,
	output logic [sdrt_pkg::KEY_W-1:0]     out_key
);

	localparam int CAP = sdrt_pkg::CAPACITY;

	// captured command
	sdrt_pkg::cmd_t cmd_s1;
	sdrt_pkg::key_t key_s1;
	sdrt_pkg::tag_t tag_s1;
	sdrt_pkg::idx_t pos_s1;

	sdrt_pkg::key_t key_q [CAP];
	sdrt_pkg::tag_t tag_q [CAP];
	sdrt_pkg::key_t key_nxt [CAP];
	sdrt_pkg::tag_t tag_nxt [CAP];
	sdrt_pkg::cnt_t count_q, count_nxt;

	sdrt_pkg::status_t status_q, status_nxt;
	sdrt_pkg::cnt_t out_count_q;
	sdrt_pkg::tag_t out_tag_q, rd_tag;
	sdrt_pkg::key_t out_key_q, rd_key;

	sdrt_pkg::key_t key_calc;
	logic [CAP-1:0] le;
	logic do_ins, do_rem;
	logic pos_bad;

	assign key_calc = sdrt_pkg::KEY_W'(birth_year) * sdrt_pkg::KEY_W'(sdrt_pkg::DAYS_PER_YEAR)
		+ sdrt_pkg::KEY_W'(birth_month) * sdrt_pkg::KEY_W'(sdrt_pkg::DAYS_PER_MONTH)
		+ sdrt_pkg::KEY_W'(birth_day);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_s1 <= sdrt_pkg::cmd_t'(cmd);
			key_s1 <= key_calc;
			tag_s1 <= record_tag;
			pos_s1 <= position;
		end
	end

	// cells at or below the new key keep their place; the sorted order makes this a prefix
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			le[i] = (sdrt_pkg::CNT_W'(i) < count_q) && (key_q[i] <= key_s1);
		end
	end

	assign pos_bad = sdrt_pkg::CNT_W'(pos_s1) >= count_q;

	always_comb begin
		status_nxt = sdrt_pkg::ST_OK;
		count_nxt = count_q;
		rd_tag = '0;
		rd_key = '0;
		do_ins = 1'b0;
		do_rem = 1'b0;
		case (cmd_s1)
			sdrt_pkg::CMD_ADD: begin
				if (count_q == sdrt_pkg::CNT_W'(CAP)) begin
					status_nxt = sdrt_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			sdrt_pkg::CMD_REMOVE: begin
				if (pos_bad) begin
					status_nxt = sdrt_pkg::ST_RANGE;
				end else begin
					do_rem = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			sdrt_pkg::CMD_READ: begin
				if (pos_bad) begin
					status_nxt = sdrt_pkg::ST_RANGE;
				end else begin
					rd_tag = tag_q[pos_s1];
					rd_key = key_q[pos_s1];
				end
			end
			default: begin
				count_nxt = '0;
			end
		endcase
	end

	for (genvar g = 0; g < CAP; g++) begin : g_cell
		logic take_new;
		sdrt_pkg::key_t up_key;
		sdrt_pkg::tag_t up_tag;
		sdrt_pkg::key_t dn_key;
		sdrt_pkg::tag_t dn_tag;

		if (g == 0) begin : g_first
			assign take_new = 1'b1;
			assign up_key = key_s1;
			assign up_tag = tag_s1;
		end else begin : g_rest
			assign take_new = le[g-1];
			assign up_key = key_q[g-1];
			assign up_tag = tag_q[g-1];
		end

		if (g == CAP - 1) begin : g_last
			assign dn_key = key_q[g];
			assign dn_tag = tag_q[g];
		end else begin : g_inner
			assign dn_key = key_q[g+1];
			assign dn_tag = tag_q[g+1];
		end

		always_comb begin
			key_nxt[g] = key_q[g];
			tag_nxt[g] = tag_q[g];
			if (do_ins && !le[g]) begin
				key_nxt[g] = take_new ? key_s1 : up_key;
				tag_nxt[g] = take_new ? tag_s1 : up_tag;
			end else if (do_rem && (sdrt_pkg::CNT_W'(g) >= sdrt_pkg::CNT_W'(pos_s1))) begin
				key_nxt[g] = dn_key;
				tag_nxt[g] = dn_tag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			for (int i = 0; i < CAP; i++) begin
				key_q[i] <= key_nxt[i];
				tag_q[i] <= tag_nxt[i];
			end
			status_q <= status_nxt;
			out_count_q <= count_nxt;
			out_tag_q <= rd_tag;
			out_key_q <= rd_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.exec) begin
			count_q <= count_nxt;
		end
	end

	assign status = status_q;
	assign entry_count = out_count_q;
	assign out_tag = out_tag_q;
	assign out_key = out_key_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sdrt_pkg::CNT_W'(CAP))
		else $error("fill count beyond capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && cmd_s1 == sdrt_pkg::CMD_CLEAR |=> count_q == '0)
		else $error("clear left entries behind");

	a_le_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && do_ins |-> $countones(le) == $countones(le & ((le << 1) | 1)))
		else $error("table order broken");

endmodule

// ===== hw/rtl/sorted_date_record_table.sv =====
// Sorted table of up to sdrt_pkg::CAPACITY (16) records, each a tag and a date key
// year*365 + month*30 + day, kept in ascending key order with a new record placed after
// equal keys. A command is first taken in with its date key, formed from year, month and day
// through two small multipliers; in the execute state all cells are then compared against it
// at once and shifted in place, and no new command is taken before that. The result sits
// in an output register, and the next command is taken in the cycle its result is taken.
// Status is 0 ok, 1 position out of range, 2 table full; tag and key are zero but for a
// successful read.
module sorted_date_record_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [sdrt_pkg::TAG_W-1:0]   record_tag,
	input  logic [sdrt_pkg::DAY_W-1:0]   birth_day,
	input  logic [sdrt_pkg::MONTH_W-1:0] birth_month,
	input  logic [sdrt_pkg::YEAR_W-1:0]  birth_year,
	input  logic [sdrt_pkg::IDX_W-1:0]   position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [sdrt_pkg::CNT_W-1:0]   entry_count,
	output logic [sdrt_pkg::TAG_W-1:0]   out_tag,
	output logic [sdrt_pkg::KEY_W-1:0]   out_key
);

	sdrt_pkg::ctl_t ctl;

	sdrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctl      (ctl)
	);

	sdrt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd),
		.record_tag (record_tag),
		.birth_day  (birth_day),
		.birth_month(birth_month),
		.birth_year (birth_year),
		.position   (position),
		.status     (status),
		.entry_count(entry_count),
		.out_tag    (out_tag),
		.out_key    (out_key)
	);

endmodule

// ===== tb/sorted_date_record_table_tb.sv =====
// testbench of the sorted date record table: directed command table, then random commands
module sorted_date_record_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		sdrt_pkg::cmd_t               op;
		sdrt_pkg::tag_t               tag;
		logic [sdrt_pkg::DAY_W-1:0]   day;
		logic [sdrt_pkg::MONTH_W-1:0] month;
		logic [sdrt_pkg::YEAR_W-1:0]  year;
		sdrt_pkg::idx_t               pos;
	} table_cmd_t;

	typedef struct packed {
		sdrt_pkg::status_t st;
		sdrt_pkg::cnt_t    count;
		sdrt_pkg::tag_t    tag;
		sdrt_pkg::key_t    key;
	} table_result_t;

	// one row of the directed table; fill > 0 sends that many adds of random dates instead
	typedef struct packed {
		sdrt_pkg::cmd_t               op;
		sdrt_pkg::tag_t               tag;
		logic [sdrt_pkg::DAY_W-1:0]   day;
		logic [sdrt_pkg::MONTH_W-1:0] month;
		logic [sdrt_pkg::YEAR_W-1:0]  year;
		sdrt_pkg::idx_t               pos;
		logic [4:0]                   fill;
		logic                         typed;
		sdrt_pkg::status_t            st;
		sdrt_pkg::cnt_t               count;
		sdrt_pkg::tag_t               rtag;
		sdrt_pkg::key_t               rkey;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 21;
	localparam int PHASE_ITEMS = 150;
	localparam sdrt_pkg::key_t TOP_KEY = 21'd1495156;

	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// op, tag, day, month, year, pos, fill, typed,
		//   status, count, rtag, rkey
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd0,  0, 1,
			sdrt_pkg::ST_RANGE, 5'd0,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_REMOVE, 8'h00, 5'd0,  4'd0,  12'd0,    4'd15, 0, 1,
			sdrt_pkg::ST_RANGE, 5'd0,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_CLEAR,  8'h00, 5'd0,  4'd0,  12'd0,    4'd0,  0, 1,
			sdrt_pkg::ST_OK,    5'd0,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_ADD,    8'hFF, 5'd31, 4'd15, 12'd4095, 4'd0,  0, 1,
			sdrt_pkg::ST_OK,    5'd1,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_ADD,    8'h00, 5'd0,  4'd0,  12'd0,    4'd15, 0, 1,
			sdrt_pkg::ST_OK,    5'd2,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd0,  0, 1,
			sdrt_pkg::ST_OK,    5'd2,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd1,  0, 1,
			sdrt_pkg::ST_OK,    5'd2,  8'hFF, TOP_KEY},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd2,  0, 1,
			sdrt_pkg::ST_RANGE, 5'd2,  8'h00, 21'd0},
		// equal key goes after the older entry
		'{sdrt_pkg::CMD_ADD,    8'h5A, 5'd31, 4'd15, 12'd4095, 4'd0,  0, 1,
			sdrt_pkg::ST_OK,    5'd3,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd2,  0, 1,
			sdrt_pkg::ST_OK,    5'd3,  8'h5A, TOP_KEY},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd1,  0, 1,
			sdrt_pkg::ST_OK,    5'd3,  8'hFF, TOP_KEY},
		'{sdrt_pkg::CMD_ADD,    8'h3C, 5'd15, 4'd6,  12'd2000, 4'd0,  0, 1,
			sdrt_pkg::ST_OK,    5'd4,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd1,  0, 0,
			sdrt_pkg::ST_OK,    5'd0,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_REMOVE, 8'h00, 5'd0,  4'd0,  12'd0,    4'd0,  0, 1,
			sdrt_pkg::ST_OK,    5'd3,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd0,  0, 0,
			sdrt_pkg::ST_OK,    5'd0,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_ADD,    8'h00, 5'd0,  4'd0,  12'd0,    4'd0, 13, 0,
			sdrt_pkg::ST_OK,    5'd0,  8'h00, 21'd0},
		// full table refuses the add
		'{sdrt_pkg::CMD_ADD,    8'h77, 5'd1,  4'd1,  12'd1,    4'd0,  0, 1,
			sdrt_pkg::ST_FULL,  5'd16, 8'h00, 21'd0},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd15, 0, 0,
			sdrt_pkg::ST_OK,    5'd0,  8'h00, 21'd0},
		'{sdrt_pkg::CMD_REMOVE, 8'h00, 5'd0,  4'd0,  12'd0,    4'd15, 0, 1,
			sdrt_pkg::ST_OK,    5'd15, 8'h00, 21'd0},
		'{sdrt_pkg::CMD_READ,   8'h00, 5'd0,  4'd0,  12'd0,    4'd15, 0, 1,
			sdrt_pkg::ST_RANGE, 5'd15, 8'h00, 21'd0},
		'{sdrt_pkg::CMD_CLEAR,  8'h00, 5'd0,  4'd0,  12'd0,    4'd0,  0, 1,
			sdrt_pkg::ST_OK,    5'd0,  8'h00, 21'd0}
	};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [1:0]                   cmd = sdrt_pkg::CMD_CLEAR;
	sdrt_pkg::tag_t               record_tag = '0;
	logic [sdrt_pkg::DAY_W-1:0]   birth_day = '0;
	logic [sdrt_pkg::MONTH_W-1:0] birth_month = '0;
	logic [sdrt_pkg::YEAR_W-1:0]  birth_year = '0;
	sdrt_pkg::idx_t               position = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [1:0]                   status;
	sdrt_pkg::cnt_t               entry_count;
	sdrt_pkg::tag_t               out_tag;
	sdrt_pkg::key_t               out_key;

	sdrt_pkg::key_t model_keys [sdrt_pkg::CAPACITY];
	sdrt_pkg::tag_t model_tags [sdrt_pkg::CAPACITY];
	int             model_count = 0;
	table_result_t  pending_results [$];
	int unsigned    mismatch_count = 0;
	int unsigned    send_idle_pct = 0;
	int unsigned    recv_stall_pct = 0;
	int unsigned    hold_off_left = 0;

	sorted_date_record_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.record_tag(record_tag),
		.birth_day(birth_day),
		.birth_month(birth_month),
		.birth_year(birth_year),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count),
		.out_tag(out_tag),
		.out_key(out_key)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sdrt_pkg::key_t date_key(table_cmd_t c);
		int unsigned k;
		k = c.year * sdrt_pkg::DAYS_PER_YEAR + c.month * sdrt_pkg::DAYS_PER_MONTH + c.day;
		return sdrt_pkg::key_t'(k);
	endfunction

	// applies one command to the behavioural table and gives its result
	function automatic table_result_t table_apply(table_cmd_t c);
		table_result_t r;
		sdrt_pkg::key_t k;
		int slot;
		r = '0;
		r.st = sdrt_pkg::ST_OK;
		case (c.op)
			sdrt_pkg::CMD_ADD: begin
				if (model_count >= sdrt_pkg::CAPACITY) begin
					r.st = sdrt_pkg::ST_FULL;
				end else begin
					k = date_key(c);
					slot = 0;
					while (slot < model_count && model_keys[slot] <= k)
						slot++;
					for (int i = model_count; i > slot; i--) begin
						model_keys[i] = model_keys[i-1];
						model_tags[i] = model_tags[i-1];
					end
					model_keys[slot] = k;
					model_tags[slot] = c.tag;
					model_count++;
				end
			end
			sdrt_pkg::CMD_REMOVE: begin
				if (int'(c.pos) >= model_count) begin
					r.st = sdrt_pkg::ST_RANGE;
				end else begin
					for (int i = c.pos; i + 1 < model_count; i++) begin
						model_keys[i] = model_keys[i+1];
						model_tags[i] = model_tags[i+1];
					end
					model_count--;
				end
			end
			sdrt_pkg::CMD_READ: begin
				if (int'(c.pos) >= model_count) begin
					r.st = sdrt_pkg::ST_RANGE;
				end else begin
					r.tag = model_tags[c.pos];
					r.key = model_keys[c.pos];
				end
			end
			default: model_count = 0;
		endcase
		r.count = sdrt_pkg::cnt_t'(model_count);
		return r;
	endfunction

	function automatic table_cmd_t random_cmd();
		table_cmd_t c;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 42)
			c.op = sdrt_pkg::CMD_ADD;
		else if (pick < 70)
			c.op = sdrt_pkg::CMD_READ;
		else if (pick < 97)
			c.op = sdrt_pkg::CMD_REMOVE;
		else
			c.op = sdrt_pkg::CMD_CLEAR;
		c.tag = sdrt_pkg::tag_t'($urandom);
		pick = $urandom_range(99);
		if (pick < 25) begin
			// narrow pool of dates so that equal keys turn up often
			c.year = sdrt_pkg::YEAR_W'(2000 + $urandom_range(1));
			c.month = 4'd1;
			c.day = sdrt_pkg::DAY_W'(1 + $urandom_range(1));
		end else if (pick < 35) begin
			// raw field values, outside the calendar too
			c.year = sdrt_pkg::YEAR_W'($urandom);
			c.month = sdrt_pkg::MONTH_W'($urandom);
			c.day = sdrt_pkg::DAY_W'($urandom);
		end else begin
			c.year = sdrt_pkg::YEAR_W'($urandom);
			c.month = sdrt_pkg::MONTH_W'($urandom_range(12, 1));
			c.day = sdrt_pkg::DAY_W'($urandom_range(31, 1));
		end
		if (model_count > 0 && $urandom_range(99) < 80)
			c.pos = sdrt_pkg::idx_t'($urandom_range(model_count - 1));
		else
			c.pos = sdrt_pkg::idx_t'($urandom);
		return c;
	endfunction

	// offers one command, waits for its transfer and files the expected result
	task automatic send_cmd(table_cmd_t c, bit typed, table_result_t typed_res);
		table_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c.op;
		record_tag <= c.tag;
		birth_day <= c.day;
		birth_month <= c.month;
		birth_year <= c.year;
		position <= c.pos;
		do @(posedge clk); while (!in_ready);
		r = table_apply(c);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no command waiting: status %0d count %0d",
					$time, status, entry_count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.st, status);
				check_field("entry_count", want.count, entry_count);
				check_field("out_tag", want.tag, out_tag);
				check_field("out_key", want.key, out_key);
			end
		end
	end

	// receiver: random stalls, and a long hold-off counted here when asked for
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				out_ready <= 1'b0;
				hold_off_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int unsigned idle_by_phase [4];
		int unsigned stall_by_phase [4];
		table_cmd_t c;
		table_result_t r;
		directed_row_t row;
		idle_by_phase = '{0, 73, 0, 38};
		stall_by_phase = '{0, 0, 73, 38};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[n]) begin
			row = DIRECTED[n];
			if (row.fill != 0) begin
				repeat (row.fill) begin
					c = random_cmd();
					c.op = sdrt_pkg::CMD_ADD;
					send_cmd(c, 1'b0, '0);
				end
			end else begin
				c = '{op: row.op, tag: row.tag, day: row.day, month: row.month,
					year: row.year, pos: row.pos};
				r = '{st: row.st, count: row.count, tag: row.rtag, key: row.rkey};
				send_cmd(c, row.typed, r);
			end
		end
		in_valid <= 1'b0;
		drain_results();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_by_phase[p];
			recv_stall_pct = stall_by_phase[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long receiver hold-off while the sender keeps offering
				if (p == 0 && i == 50)
					hold_off_left = 80;
				send_cmd(random_cmd(), 1'b0, '0);
			end
			// sender pauses until every result of the phase has come
			in_valid <= 1'b0;
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
